FILE: src/bpra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page run allocator package
// Shared types and constants for the page run allocator and its parts.
// ----------------------------------------------------------------------------
package bpra_pkg;

  localparam int unsigned COUNT_W = 11;
  localparam logic [31:0] BASE_RESET = 32'h0010_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NORUN   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: src/bpra_ram.sv
// ----------------------------------------------------------------------------
// Bitmap page run allocator word memory
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bpra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bpra_div.sv
// ----------------------------------------------------------------------------
// Bitmap page run allocator word divider
// Restoring divider by a constant, one quotient bit per cycle; splits a page
// index into its bitmap word index and bit offset.
// ----------------------------------------------------------------------------
module bpra_div #(
  parameter int unsigned NUM_W = 11,
  parameter int unsigned DEN   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [NUM_W-1:0]            dividend_i,
  output logic [NUM_W-1:0]            quotient_o,
  output logic [$clog2(DEN)-1:0]      remainder_o,
  output bpra_pkg::div_status_t       status_o
);

  localparam int unsigned REM_W = $clog2(DEN);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [REM_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = (trial >= (REM_W + 1)'(DEN));

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], ge};
      rem_d = ge ? REM_W'(trial - (REM_W + 1)'(DEN)) : trial[REM_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quotient_o    = num_q;
  assign remainder_o   = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

FILE: src/bitmap_page_run_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap page run allocator
// First-fit allocator of contiguous page runs over a used-page bitmap.
// ----------------------------------------------------------------------------
// After reset the block clears its bitmap memory, one word per cycle, and
// accepts no transaction until that is done. One request is worked on at a
// time, and its result goes to an output register so that the next request
// can be taken while the result waits. An allocate reads the bitmap words in
// order from the word memory; a fully used word, or a free word that cannot
// finish the run, is passed over in S_SCAN_WORD, and any other word is
// inspected and then shifted through bit by bit in S_SCAN_BIT. Marking the run
// then writes each whole word directly and each of at most two partial words
// through S_MOD_LOAD and S_MOD_BIT. A free runs two checks (S_FCHK_ADDR,
// S_FCHK_RANGE), splits the first page index in the word divider, then does
// the same marking. Each result passes through S_RESP to the output register.
module bitmap_page_run_allocator_core #(
  parameter int unsigned PAGE_TOTAL = 1024,
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [10:0] page_count_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] run_address_o,
  output logic [1:0]  status_o
);

  localparam int unsigned WORD_COUNT = (PAGE_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned PW  = $clog2(PAGE_TOTAL + 1);
  localparam int unsigned WCW = $clog2(WORD_COUNT + 1);
  localparam int unsigned AW  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BW  = $clog2(WORD_BITS);
  localparam int unsigned FW  = 32 - PAGE_SHIFT;
  localparam int unsigned CW  = bpra_pkg::COUNT_W;
  localparam int unsigned MW0 = (FW > PW) ? FW : PW;
  localparam int unsigned MW1 = (MW0 > CW) ? MW0 : CW;
  localparam int unsigned XW  = MW1 + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_WORD,
    S_SCAN_BIT,
    S_MOD_WORD,
    S_MOD_LOAD,
    S_MOD_BIT,
    S_FCHK_ADDR,
    S_FCHK_RANGE,
    S_FDIV,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [31:0]           base_q, base_d;
  logic [CW-1:0]         n_q, n_d;
  logic [31:0]           faddr_q, faddr_d;
  logic [WCW-1:0]        word_q, word_d;
  logic [PW-1:0]         page_q, page_d;
  logic [PW-1:0]         run_q, run_d;
  logic [PW-1:0]         start_page_q, start_page_d;
  logic [WCW-1:0]        start_word_q, start_word_d;
  logic [BW-1:0]         start_bit_q, start_bit_d;
  logic [BW-1:0]         bit_q, bit_d;
  logic [WORD_BITS-1:0]  sh_q, sh_d;
  logic [WCW-1:0]        mw_q, mw_d;
  logic [BW-1:0]         mb_q, mb_d;
  logic [CW-1:0]         r_q, r_d;
  logic                  val_q, val_d;
  logic [XW-1:0]         first_q, first_d;
  logic [WCW-1:0]        clr_q, clr_d;
  logic [31:0]           res_addr_q, res_addr_d;
  bpra_pkg::status_e     res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_addr_q, out_addr_d;
  bpra_pkg::status_e     out_st_q, out_st_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [AW-1:0]         rd_addr;
  logic [WORD_BITS-1:0]  ram_rdata;

  logic                  div_start;
  logic [PW-1:0]         div_quo;
  logic [BW-1:0]         div_rem;
  bpra_pkg::div_status_t div_stat;

  logic [XW-1:0]         n_x, run_x, page_x, r_x, wb_x, total_x, run_inc_x;
  logic [WCW-1:0]        word_nx, mw_nx;
  logic                  bit_last, last_word;
  logic [32:0]           diff;
  logic [31:0]           start_off;
  logic                  sel_mod, new_bit;
  logic [WORD_BITS-1:0]  sh_mod;
  logic [CW-1:0]         r_mod;

  assign n_x       = XW'(n_q);
  assign run_x     = XW'(run_q);
  assign page_x    = XW'(page_q);
  assign r_x       = XW'(r_q);
  assign wb_x      = XW'(WORD_BITS);
  assign total_x   = XW'(PAGE_TOTAL);
  assign run_inc_x = run_x + XW'(1);
  assign word_nx   = word_q + 1'b1;
  assign mw_nx     = mw_q + 1'b1;
  assign bit_last  = (bit_q == BW'(WORD_BITS - 1));
  assign last_word = (word_q == WCW'(WORD_COUNT - 1));
  assign diff      = {1'b0, faddr_q} - {1'b0, base_q};
  assign start_off = 32'({{32{1'b0}}, start_page_q} << PAGE_SHIFT);
  assign sel_mod   = (bit_q >= mb_q) && (r_q != '0);
  assign new_bit   = sel_mod ? val_q : sh_q[0];
  assign sh_mod    = {new_bit, sh_q[WORD_BITS-1:1]};
  assign r_mod     = sel_mod ? (r_q - 1'b1) : r_q;

  bpra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  bpra_div #(
    .NUM_W (PW),
    .DEN   (WORD_BITS)
  ) u_word_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (first_q[PW-1:0]),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .status_o    (div_stat)
  );

  always_comb begin
    state_d      = state_q;
    base_d       = cfg_we_i ? cfg_data_i : base_q;
    n_d          = n_q;
    faddr_d      = faddr_q;
    word_d       = word_q;
    page_d       = page_q;
    run_d        = run_q;
    start_page_d = start_page_q;
    start_word_d = start_word_q;
    start_bit_d  = start_bit_q;
    bit_d        = bit_q;
    sh_d         = sh_q;
    mw_d         = mw_q;
    mb_d         = mb_q;
    r_d          = r_q;
    val_d        = val_q;
    first_d      = first_q;
    clr_d        = clr_q;
    res_addr_d   = res_addr_q;
    res_st_d     = res_st_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_addr_d   = out_addr_q;
    out_st_d     = out_st_q;
    ram_we       = 1'b0;
    ram_waddr    = mw_q[AW-1:0];
    ram_wdata    = '0;
    rd_addr      = word_q[AW-1:0];
    div_start    = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        clr_d     = clr_q + 1'b1;
        if (clr_q == WCW'(WORD_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          n_d        = page_count_i;
          faddr_d    = free_address_i;
          res_addr_d = '0;
          if (page_count_i == '0) begin
            res_st_d = bpra_pkg::ST_INVALID;
            state_d  = S_RESP;
          end else if (op_i == bpra_pkg::OP_FREE) begin
            state_d = S_FCHK_ADDR;
          end else if (XW'(page_count_i) > total_x) begin
            res_st_d = bpra_pkg::ST_NORUN;
            state_d  = S_RESP;
          end else begin
            word_d       = '0;
            page_d       = '0;
            run_d        = '0;
            start_page_d = '0;
            start_word_d = '0;
            start_bit_d  = '0;
            bit_d        = '0;
            rd_addr      = '0;
            state_d      = S_SCAN_WORD;
          end
        end
      end
      S_SCAN_WORD: begin
        if (ram_rdata == '1 || (ram_rdata == '0 && (run_x + wb_x) < n_x)) begin
          if (ram_rdata == '1) begin
            run_d        = '0;
            start_page_d = PW'(page_x + wb_x);
            start_word_d = word_nx;
            start_bit_d  = '0;
          end else begin
            run_d = PW'(run_x + wb_x);
          end
          page_d  = PW'(page_x + wb_x);
          word_d  = word_nx;
          rd_addr = word_nx[AW-1:0];
          if (last_word) begin
            res_st_d = bpra_pkg::ST_NORUN;
            state_d  = S_RESP;
          end
        end else begin
          sh_d    = ram_rdata;
          bit_d   = '0;
          state_d = S_SCAN_BIT;
        end
      end
      S_SCAN_BIT: begin
        if (page_q == PW'(PAGE_TOTAL)) begin
          res_st_d = bpra_pkg::ST_NORUN;
          state_d  = S_RESP;
        end else begin
          page_d = page_q + 1'b1;
          sh_d   = sh_q >> 1;
          bit_d  = bit_q + 1'b1;
          if (sh_q[0]) begin
            run_d        = '0;
            start_page_d = page_q + 1'b1;
            if (bit_last) begin
              start_word_d = word_nx;
              start_bit_d  = '0;
            end else begin
              start_word_d = word_q;
              start_bit_d  = bit_q + 1'b1;
            end
          end else begin
            run_d = run_q + 1'b1;
          end
          if (!sh_q[0] && run_inc_x == n_x) begin
            res_addr_d = base_q + start_off;
            res_st_d   = bpra_pkg::ST_DONE;
            mw_d       = start_word_q;
            mb_d       = start_bit_q;
            r_d        = n_q;
            val_d      = 1'b1;
            state_d    = S_MOD_WORD;
          end else if (bit_last) begin
            bit_d   = '0;
            word_d  = word_nx;
            rd_addr = word_nx[AW-1:0];
            if (last_word) begin
              res_st_d = bpra_pkg::ST_NORUN;
              state_d  = S_RESP;
            end else begin
              state_d = S_SCAN_WORD;
            end
          end
        end
      end
      S_MOD_WORD: begin
        if (mb_q == '0 && r_x >= wb_x) begin
          ram_we    = 1'b1;
          ram_waddr = mw_q[AW-1:0];
          ram_wdata = {WORD_BITS{val_q}};
          r_d       = CW'(r_x - wb_x);
          mw_d      = mw_nx;
          if (r_x == wb_x) begin
            state_d = S_RESP;
          end
        end else begin
          rd_addr = mw_q[AW-1:0];
          state_d = S_MOD_LOAD;
        end
      end
      S_MOD_LOAD: begin
        sh_d    = ram_rdata;
        bit_d   = '0;
        state_d = S_MOD_BIT;
      end
      S_MOD_BIT: begin
        sh_d  = sh_mod;
        r_d   = r_mod;
        bit_d = bit_q + 1'b1;
        if (bit_last) begin
          ram_we    = 1'b1;
          ram_waddr = mw_q[AW-1:0];
          ram_wdata = sh_mod;
          mw_d      = mw_nx;
          mb_d      = '0;
          bit_d     = '0;
          state_d   = (r_mod == '0) ? S_RESP : S_MOD_WORD;
        end
      end
      S_FCHK_ADDR: begin
        if (diff[32] || diff[PAGE_SHIFT-1:0] != '0) begin
          res_st_d = bpra_pkg::ST_INVALID;
          state_d  = S_RESP;
        end else begin
          first_d = XW'(diff[31:PAGE_SHIFT]);
          state_d = S_FCHK_RANGE;
        end
      end
      S_FCHK_RANGE: begin
        if ((first_q + n_x) > total_x) begin
          res_st_d = bpra_pkg::ST_INVALID;
          state_d  = S_RESP;
        end else begin
          div_start = 1'b1;
          state_d   = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_stat.done) begin
          mw_d     = div_quo[WCW-1:0];
          mb_d     = div_rem;
          r_d      = n_q;
          val_d    = 1'b0;
          res_st_d = bpra_pkg::ST_DONE;
          state_d  = S_MOD_WORD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      base_q       <= bpra_pkg::BASE_RESET;
      n_q          <= '0;
      faddr_q      <= '0;
      word_q       <= '0;
      page_q       <= '0;
      run_q        <= '0;
      start_page_q <= '0;
      start_word_q <= '0;
      start_bit_q  <= '0;
      bit_q        <= '0;
      sh_q         <= '0;
      mw_q         <= '0;
      mb_q         <= '0;
      r_q          <= '0;
      val_q        <= 1'b0;
      first_q      <= '0;
      clr_q        <= '0;
      res_addr_q   <= '0;
      res_st_q     <= bpra_pkg::ST_DONE;
      out_valid_q  <= 1'b0;
      out_addr_q   <= '0;
      out_st_q     <= bpra_pkg::ST_DONE;
    end else begin
      state_q      <= state_d;
      base_q       <= base_d;
      n_q          <= n_d;
      faddr_q      <= faddr_d;
      word_q       <= word_d;
      page_q       <= page_d;
      run_q        <= run_d;
      start_page_q <= start_page_d;
      start_word_q <= start_word_d;
      start_bit_q  <= start_bit_d;
      bit_q        <= bit_d;
      sh_q         <= sh_d;
      mw_q         <= mw_d;
      mb_q         <= mb_d;
      r_q          <= r_d;
      val_q        <= val_d;
      first_q      <= first_d;
      clr_q        <= clr_d;
      res_addr_q   <= res_addr_d;
      res_st_q     <= res_st_d;
      out_valid_q  <= out_valid_d;
      out_addr_q   <= out_addr_d;
      out_st_q     <= out_st_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign run_address_o = out_addr_q;
  assign status_o      = out_st_q;

  a_error_no_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bpra_pkg::ST_DONE) |-> (run_address_o == '0))
    else $error("Failed transaction carries a nonzero run address.");

  a_scan_run_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_WORD || state_q == S_SCAN_BIT) |-> (run_x < n_x))
    else $error("Scan run length reached the request without a match.");

  a_scan_word_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_WORD) |-> (XW'(word_q) < XW'(WORD_COUNT)))
    else $error("Scan word index ran past the bitmap.");

  a_mark_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD_WORD || state_q == S_MOD_LOAD || state_q == S_MOD_BIT)
      |-> (r_q <= n_q))
    else $error("Remaining page count exceeds the request.");

  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FDIV) |-> (div_stat.busy || div_stat.done))
    else $error("Waiting on the word divider while it is idle.");

endmodule
